@@ hw/rtl/ffba_pkg.sv @@
// ffba_pkg: shared constants, payload structs and controller/datapath command types
// for the first-fit block allocator; no dependencies
`default_nettype none

package ffba_pkg;

  // arena geometry
  localparam int ARENA_BYTES  = 8192;
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;

  localparam int AW     = 13;                      // byte offset / size width
  localparam int IDX_W  = 7;                       // holds 0..MAX_BLOCKS+1
  localparam int ADDR_W = 6;                       // table address width

  localparam logic [AW-1:0]    HDR13     = AW'(HEADER_BYTES);
  localparam logic [AW:0]      HDR14     = (AW+1)'(HEADER_BYTES);
  localparam logic [AW-1:0]    INIT_SIZE = AW'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [IDX_W-1:0] MAX_CNT   = IDX_W'(MAX_BLOCKS);

  // operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic          operation;
    logic [AW-1:0] request_bytes;
    logic [AW-1:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [AW-1:0] payload_offset;
    status_t       status;
  } out_item_t;

  // one block table entry
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          free;
  } entry_t;

  // what the evaluate step decided
  typedef enum logic [1:0] {
    EV_DONE = 2'd0,
    EV_UP   = 2'd1,
    EV_NEW  = 2'd2,
    EV_DOWN = 2'd3
  } eval_t;

  typedef struct packed {
    logic init;
    logic accept;
    logic scan;
    logic eval;
    logic move_up;
    logic move_down;
    logic wr_new;
    logic shrink;
  } cmd_t;

  typedef struct packed {
    logic  hit;
    logic  miss;
    logic  up_done;
    logic  down_done;
    eval_t decision;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffba_dp.sv @@
// ffba_dp: block table memory, scan pointers, fit/merge arithmetic and result register
// depends on ffba_pkg; driven by ffba_ctrl commands
`default_nettype none

module ffba_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ffba_pkg::cmd_t       cmd,
  input  ffba_pkg::in_item_t   in_item,
  output ffba_pkg::stat_t      stat,
  output ffba_pkg::out_item_t  result
);
  import ffba_pkg::*;

  entry_t           mem [MAX_BLOCKS];
  entry_t           rd_q_r;
  entry_t           prev_r;
  entry_t           cur_r;
  in_item_t         item_r;
  out_item_t        res_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] count_r;
  logic [1:0]       n_r;
  logic             rd_act_r;

  logic              we;
  logic [ADDR_W-1:0] wa;
  entry_t            wd;

  logic             match, in_range;
  logic             issue_up, issue_down;
  logic             exact, big, full;
  logic [AW-1:0]    offs;
  logic             mp, mn;
  logic [AW-1:0]    merged;
  logic [AW-1:0]    base_start;
  logic [IDX_W-1:0] base_idx;
  logic [1:0]       n;
  logic [IDX_W-1:0] hit_p1;
  eval_t            decision;
  out_item_t        eval_res;

  // table memory, registered read
  always_ff @(posedge clk) begin
    rd_q_r <= mem[ptr_r[ADDR_W-1:0]];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // scan compare on the entry just read
  always_comb begin
    if (item_r.operation == OP_ALLOC) begin
      match = rd_q_r.free && (rd_q_r.size >= item_r.request_bytes);
    end else begin
      match = ({1'b0, rd_q_r.start} + HDR14) == {1'b0, item_r.release_offset};
    end
    in_range   = rd_idx_r < count_r;
    issue_up   = ptr_r > hit_idx_r;
    issue_down = ptr_r < count_r;
  end

  // fit and merge arithmetic for the evaluate step
  always_comb begin
    hit_p1     = hit_idx_r + IDX_W'(1);
    exact      = cur_r.size == item_r.request_bytes;
    big        = {1'b0, cur_r.size} > ({1'b0, item_r.request_bytes} + HDR14);
    full       = count_r == MAX_CNT;
    offs       = cur_r.start + HDR13;
    mp         = (hit_idx_r != '0) && prev_r.free;
    mn         = (hit_p1 < count_r) && rd_q_r.free;
    merged     = cur_r.size + (mp ? prev_r.size + HDR13 : '0)
                 + (mn ? rd_q_r.size + HDR13 : '0);
    base_start = mp ? prev_r.start : cur_r.start;
    base_idx   = mp ? hit_idx_r - IDX_W'(1) : hit_idx_r;
    n          = {1'b0, mp} + {1'b0, mn};
    decision   = EV_DONE;
    eval_res   = '{payload_offset: '0, status: ST_OK};
    if (item_r.operation == OP_ALLOC) begin
      if (exact) begin
        eval_res = '{payload_offset: offs, status: ST_OK};
      end else if (big && full) begin
        eval_res = '{payload_offset: '0, status: ST_FULL};
      end else if (big) begin
        eval_res = '{payload_offset: offs, status: ST_OK};
        decision = (count_r - IDX_W'(1) > hit_idx_r) ? EV_UP : EV_NEW;
      end else begin
        eval_res = '{payload_offset: '0, status: ST_NO_FIT};
      end
    end else if (!cur_r.free && n != 2'd0) begin
      decision = EV_DOWN;
    end
  end

  // table write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rd_q_r;
    priority if (cmd.init) begin
      we = 1'b1;
      wd = '{start: '0, size: INIT_SIZE, free: 1'b1};
    end else if (cmd.eval) begin
      if (item_r.operation == OP_ALLOC) begin
        we = exact || (big && !full);
        wa = hit_idx_r[ADDR_W-1:0];
        wd = '{start: cur_r.start, size: exact ? cur_r.size : item_r.request_bytes,
               free: 1'b0};
      end else begin
        we = !cur_r.free;
        wa = base_idx[ADDR_W-1:0];
        wd = '{start: base_start, size: merged, free: 1'b1};
      end
    end else if (cmd.move_up) begin
      we = rd_act_r;
      wa = ADDR_W'(rd_idx_r + IDX_W'(1));
    end else if (cmd.move_down) begin
      we = rd_act_r;
      wa = ADDR_W'(rd_idx_r - {{(IDX_W-2){1'b0}}, n_r});
    end else if (cmd.wr_new) begin
      we = 1'b1;
      wa = hit_p1[ADDR_W-1:0];
      wd = '{start: cur_r.start + HDR13 + item_r.request_bytes,
             size: cur_r.size - item_r.request_bytes - HDR13, free: 1'b1};
    end
  end

  // control registers: pointers and block count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= IDX_W'(1);
      rd_act_r <= 1'b0;
      ptr_r    <= '0;
    end else begin
      if (cmd.init) begin
        count_r <= IDX_W'(1);
      end else if (cmd.wr_new) begin
        count_r <= count_r + IDX_W'(1);
      end else if (cmd.shrink) begin
        count_r <= count_r - {{(IDX_W-2){1'b0}}, n_r};
      end
      if (cmd.accept) begin
        ptr_r    <= '0;
        rd_act_r <= 1'b0;
      end else if (cmd.scan) begin
        ptr_r    <= ptr_r + IDX_W'(1);
        rd_act_r <= 1'b1;
      end else if (cmd.eval) begin
        ptr_r    <= (item_r.operation == OP_ALLOC) ? count_r - IDX_W'(1)
                    : base_idx + IDX_W'(1) + {{(IDX_W-2){1'b0}}, n};
        rd_act_r <= 1'b0;
      end else if (cmd.move_up) begin
        ptr_r    <= issue_up ? ptr_r - IDX_W'(1) : ptr_r;
        rd_act_r <= issue_up;
      end else if (cmd.move_down) begin
        ptr_r    <= issue_down ? ptr_r + IDX_W'(1) : ptr_r;
        rd_act_r <= issue_down;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= ptr_r;
    if (cmd.accept) begin
      item_r <= in_item;
    end
    if (cmd.scan && rd_act_r) begin
      if (stat.hit) begin
        cur_r     <= rd_q_r;
        hit_idx_r <= rd_idx_r;
      end else begin
        prev_r <= rd_q_r;
      end
      if (stat.miss) begin
        res_r <= '{payload_offset: '0,
                   status: (item_r.operation == OP_ALLOC) ? ST_NO_FIT : ST_UNKNOWN};
      end
    end
    if (cmd.eval) begin
      res_r <= eval_res;
      n_r   <= n;
    end
  end

  assign stat.hit       = cmd.scan && rd_act_r && in_range && match;
  assign stat.miss      = cmd.scan && rd_act_r && !in_range;
  assign stat.up_done   = !issue_up && !rd_act_r;
  assign stat.down_done = !issue_down && !rd_act_r;
  assign stat.decision  = decision;
  assign result         = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/ffba_ctrl.sv @@
// ffba_ctrl: sequencing state machine for the first-fit block allocator
// depends on ffba_pkg; commands ffba_dp
`default_nettype none

module ffba_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);
  import ffba_pkg::*;

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_EVAL = 8'b0000_1000,
    S_UP   = 8'b0001_0000,
    S_NEW  = 8'b0010_0000,
    S_DOWN = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_nxt = S_EVAL;
        end else if (stat.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        unique case (stat.decision)
          EV_UP:   state_nxt = S_UP;
          EV_NEW:  state_nxt = S_NEW;
          EV_DOWN: state_nxt = S_DOWN;
          default: state_nxt = S_DONE;
        endcase
      end
      S_UP: begin
        cmd.move_up = 1'b1;
        if (stat.up_done) begin
          state_nxt = S_NEW;
        end
      end
      S_NEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DOWN: begin
        cmd.move_down = 1'b1;
        if (stat.down_done) begin
          cmd.shrink = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_block_allocator_top.sv @@
// first_fit_block_allocator_top: top level joining controller and datapath
// depends on ffba_pkg, ffba_ctrl, ffba_dp
`default_nettype none

// One request is taken while busy is low and start is high; its single result
// appears on out_result for exactly one cycle with out_valid, and the receiver
// cannot stall it. A request scans the block table one entry per cycle through
// the table memory's registered read port. A split first shifts the entries
// behind the chosen block up by one, then writes the free remainder block after
// it. A release that merges moves the entries behind the merged block down. The
// shift only covers entries past the chosen one. Busy falls the cycle after the
// strobe. After reset, the init state writes the whole arena as one free block
// before busy falls.
module first_fit_block_allocator_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ffba_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ffba_pkg::out_item_t  out_result
);
  import ffba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ffba_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_item),
    .stat    (stat),
    .result  (out_result)
  );

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a nonzero offset only comes with success
  a_offset_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.payload_offset != '0) |-> out_result.status == ST_OK)
    else $error("granted offset on a failed transaction");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the first-fit block allocator
// depends on ffba_pkg and first_fit_block_allocator_top
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import ffba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_result;

  always #10 clk = ~clk;

  first_fit_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_result(out_result)
  );

  // allocator table mirror
  logic [AW-1:0] blk_start [MAX_BLOCKS];
  logic [AW-1:0] blk_size [MAX_BLOCKS];
  logic          blk_free [MAX_BLOCKS];
  int            blk_count;
  out_item_t     pending_grants[$];
  logic [AW-1:0] live_offsets[$];
  int            mismatches = 0;
  int            cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void table_reset();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_start[k] = '0;
      blk_size[k] = '0;
      blk_free[k] = 1'b0;
    end
    blk_size[0] = AW'(ARENA_BYTES - HEADER_BYTES);
    blk_free[0] = 1'b1;
    blk_count = 1;
  endfunction

  // merge neighbors that are both free
  function automatic void merge_free();
    int i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] = AW'(blk_size[i] + blk_size[i+1] + HEADER_BYTES);
        for (int k = i + 1; k + 1 < blk_count; k++) begin
          blk_start[k] = blk_start[k+1];
          blk_size[k] = blk_size[k+1];
          blk_free[k] = blk_free[k+1];
        end
        blk_count--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic out_item_t predict_grant(input in_item_t it);
    out_item_t r;
    int i;
    r.payload_offset = '0;
    r.status = ST_OK;
    if (it.operation == OP_ALLOC) begin
      for (i = 0; i < blk_count; i++)
        if (blk_free[i] && blk_size[i] >= it.request_bytes) break;
      if (i >= blk_count) begin
        r.status = ST_NO_FIT;
      end else if (blk_size[i] == it.request_bytes) begin
        blk_free[i] = 1'b0;
        r.payload_offset = AW'(blk_start[i] + HEADER_BYTES);
      end else if (int'(blk_size[i]) > int'(it.request_bytes) + HEADER_BYTES) begin
        if (blk_count >= MAX_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          for (int k = blk_count; k > i + 1; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
          end
          blk_start[i+1] = AW'(blk_start[i] + HEADER_BYTES + it.request_bytes);
          blk_size[i+1] = AW'(blk_size[i] - it.request_bytes - HEADER_BYTES);
          blk_free[i+1] = 1'b1;
          blk_count++;
          blk_size[i] = it.request_bytes;
          blk_free[i] = 1'b0;
          r.payload_offset = AW'(blk_start[i] + HEADER_BYTES);
        end
      end else begin
        r.status = ST_NO_FIT;
      end
    end else begin
      for (i = 0; i < blk_count; i++)
        if (AW'(blk_start[i] + HEADER_BYTES) == it.release_offset
            && int'(blk_start[i]) + HEADER_BYTES < 8192) break;
      if (i >= blk_count) begin
        r.status = ST_UNKNOWN;
      end else begin
        blk_free[i] = 1'b1;
        merge_free();
      end
    end
    return r;
  endfunction

  // send one transaction after a random gap
  task automatic send_item(input logic op, input logic [AW-1:0] req, input logic [AW-1:0] rel);
    in_item_t it;
    out_item_t r;
    int gap;
    gap = $urandom_range(0, 6);
    repeat (gap) @(posedge clk);
    it.operation = op;
    it.request_bytes = req;
    it.release_offset = rel;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    r = predict_grant(it);
    pending_grants.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) live_offsets.push_back(r.payload_offset);
    if (op == OP_RELEASE && r.status == ST_OK)
      foreach (live_offsets[k]) if (live_offsets[k] == rel) begin
        live_offsets.delete(k);
        break;
      end
    // let the deasserted start settle before the next transaction drives it
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        report("unexpected result", 32'(out_result), 32'd0);
      end else begin
        out_item_t e;
        e = pending_grants.pop_front();
        if (out_result.payload_offset !== e.payload_offset)
          report("payload_offset", 32'(out_result.payload_offset), 32'(e.payload_offset));
        if (out_result.status !== e.status)
          report("status", 32'(out_result.status), 32'(e.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("first_fit_block_allocator_top test failed");
      $finish;
    end
  end

  task automatic release_random();
    int k;
    if (live_offsets.size() != 0) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      send_item(OP_RELEASE, 13'($urandom), live_offsets[k]);
    end else begin
      send_item(OP_RELEASE, 13'($urandom), 13'($urandom));
    end
  endtask

  task automatic release_all();
    while (live_offsets.size() != 0) send_item(OP_RELEASE, '0, live_offsets[0]);
  endtask

  // extremes and each special case
  task automatic test_directed();
    send_item(OP_ALLOC, 13'd8191, '0);                   // no free block large enough
    send_item(OP_ALLOC, 13'd8168, 13'h1fff);             // exact fit, whole arena
    send_item(OP_ALLOC, 13'd0, '0);                      // nothing free
    send_item(OP_RELEASE, '0, 13'd24);
    send_item(OP_RELEASE, '0, 13'd24);                   // release of a free block
    send_item(OP_RELEASE, 13'h1fff, 13'd0);              // unknown offset
    send_item(OP_RELEASE, '0, 13'h1fff);
    send_item(OP_ALLOC, 13'd0, '0);                      // zero-byte split
    send_item(OP_ALLOC, 13'd100, '0);
    send_item(OP_ALLOC, 13'd8168 - 13'd48 - 13'd110, '0); // too small to split
    send_item(OP_ALLOC, 13'd200, '0);
    send_item(OP_RELEASE, '0, 13'd48);                   // merges nothing yet
    send_item(OP_ALLOC, 13'd50, '0);                     // first fit splits freed block
    release_all();
    wait_drained();
  endtask

  // fill the table until it is full
  task automatic test_table_full();
    repeat (MAX_BLOCKS + 4) send_item(OP_ALLOC, 13'($urandom_range(0, 40)), '0);
    send_item(OP_ALLOC, 13'd4000, '0);
    wait_drained();
    repeat (40) release_random();
    release_all();
    wait_drained();
  endtask

  // mostly well-formed alloc/free traffic
  task automatic test_random(input int n);
    int roll;
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        if ($urandom_range(0, 9) == 0) send_item(OP_ALLOC, 13'($urandom), 13'($urandom));
        else send_item(OP_ALLOC, 13'($urandom_range(0, 300)), 13'($urandom));
      end else if (roll < 92) begin
        release_random();
      end else begin
        send_item(OP_RELEASE, 13'($urandom), 13'($urandom));
      end
      if (j == n / 2) wait_drained();
    end
  endtask

  initial begin
    table_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(1800);
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("first_fit_block_allocator_top test passed");
    end else begin
      $display("first_fit_block_allocator_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_dp.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/first_fit_block_allocator_top.sv
bench/tb_top.sv
